// File: sv/wppp_pkg.sv
// Shared types and constants of the pure pursuit waypoint follower.
// Fixed point formats, opcodes, the CORDIC angle table and the table entry layout.
// No dependencies; imported by the top level.
package wppp_pkg;

	// Table depth default
	localparam int WAYPOINTS_DEF = 64;

	// Opcodes of an input item
	localparam logic [1:0] OP_CLEAR  = 2'd0;
	localparam logic [1:0] OP_APPEND = 2'd1;
	localparam logic [1:0] OP_ODOM   = 2'd2;
	localparam logic [1:0] OP_NOP    = 2'd3;

	// Register reset value, 0.6 rad/s in Q4.12
	localparam logic [15:0] MTR_RESET = 16'd2458;

	// Angles in units of 2^-24 rad
	localparam logic signed [27:0] PI_Z      = 28'sd52707179;
	localparam logic signed [27:0] HALF_PI_Z = 28'sd26353589;
	localparam logic signed [27:0] TWO_PI_Z  = 28'sd105414357;
	localparam int                 CORDIC_STEPS = 24;
	localparam logic [31:0]        CORDIC_GAIN  = 32'd10188014;

	// Angles in Q3.13
	localparam logic signed [17:0] PI_Q13     = 18'sd25736;
	localparam logic signed [17:0] TWO_PI_Q13 = 18'sd51472;
	localparam logic [15:0]        ANGLE_THRESH = 16'd819;

	// Floors and scale factors
	localparam logic [63:0] DSQ_FLOOR   = 64'd42949673;
	localparam logic [15:0] SPEED_FLOOR = 16'd410;
	localparam logic [31:0] SLOW_Q16    = 32'd19661;
	localparam logic signed [32:0] COORD_MAX = 33'sd2147483647;

	// One waypoint as stored in the table
	typedef struct packed {
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic signed [15:0] hdg;
		logic               stop;
		logic               hv;
		logic [15:0]        tol;
		logic [15:0]        spd;
	} wppp_entry_t;

	// atan(2^-k) in units of 2^-24 rad
	function automatic logic signed [27:0] atan_z(input logic [4:0] k);
		logic signed [27:0] r;
		case (k)
			5'd0:  r = 28'sd13176795;
			5'd1:  r = 28'sd7778717;
			5'd2:  r = 28'sd4110060;
			5'd3:  r = 28'sd2086331;
			5'd4:  r = 28'sd1047214;
			5'd5:  r = 28'sd524117;
			5'd6:  r = 28'sd262123;
			5'd7:  r = 28'sd131069;
			5'd8:  r = 28'sd65536;
			5'd9:  r = 28'sd32768;
			5'd10: r = 28'sd16384;
			5'd11: r = 28'sd8192;
			5'd12: r = 28'sd4096;
			5'd13: r = 28'sd2048;
			5'd14: r = 28'sd1024;
			5'd15: r = 28'sd512;
			5'd16: r = 28'sd256;
			5'd17: r = 28'sd128;
			5'd18: r = 28'sd64;
			5'd19: r = 28'sd32;
			5'd20: r = 28'sd16;
			5'd21: r = 28'sd8;
			5'd22: r = 28'sd4;
			5'd23: r = 28'sd2;
			default: r = 28'sd0;
		endcase
		return r;
	endfunction

endpackage

// File: sv/waypoint_pure_pursuit_follower.sv
// Waypoint follower with pure pursuit steering, fixed point, digit-serial datapath.
// Depends on wppp_pkg and wppp_ram.
//
// Use: items enter on in_valid/in_stall; op selects clear, append, odometry step or
// no-op. Every item gives exactly one result on out_valid/out_stall. The register
// max_turn_rate is written on cfg_valid/cfg_ready; cfg_ready is always high.
// Clear, append, no-op and an odometry step on an empty or completed table go
// straight to the output state and raise out_valid once the output register is
// free. An odometry step runs a bit-serial shift-add multiplier (one multiplier
// bit per cycle), a 24-step CORDIC and a restoring divider (one quotient bit per
// cycle); its run time depends on operand widths. The heading correction scales
// the turn correction and the speed on the multiplier, and an advance to the next
// waypoint does the distance squares again. One item is worked on at a time;
// in_stall is high from acceptance until the result has moved into the output
// register, and the next item can be accepted once it has.
// The output register holds a result while out_stall is high; a new item can be
// accepted during that time and its result waits until the register frees.
// Reset (arst_n low) empties the table, clears completion and the index and sets
// max_turn_rate to 0.6 rad/s. The table itself needs no clearing pass.
module waypoint_pure_pursuit_follower import wppp_pkg::*; #(
	parameter int WAYPOINTS = WAYPOINTS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [1:0]         op,
	input  logic signed [31:0] pos_x,
	input  logic signed [31:0] pos_y,
	input  logic signed [15:0] heading,
	input  logic               heading_valid,
	input  logic [15:0]        tolerance,
	input  logic [15:0]        travel_speed,
	input  logic               stop_here,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [15:0] linear_speed,
	output logic signed [15:0] turn_rate,
	output logic               done_res,
	output logic [5:0]         waypoint_index,
	output logic               rejected,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [15:0]        cfg_data
);

	localparam int IW = $clog2(WAYPOINTS);
	localparam int CW = $clog2(WAYPOINTS + 1);
	localparam int EW = $bits(wppp_entry_t);

	// Sequencer states
	localparam logic [4:0] S_IDLE = 5'd0;
	localparam logic [4:0] S_RD   = 5'd1;
	localparam logic [4:0] S_DIFF = 5'd2;
	localparam logic [4:0] S_SQS  = 5'd3;
	localparam logic [4:0] S_SQX  = 5'd4;
	localparam logic [4:0] S_SQY  = 5'd5;
	localparam logic [4:0] S_TOL  = 5'd6;
	localparam logic [4:0] S_ROTW = 5'd7;
	localparam logic [4:0] S_ROTF = 5'd8;
	localparam logic [4:0] S_CORD = 5'd9;
	localparam logic [4:0] S_GAIN = 5'd10;
	localparam logic [4:0] S_NUM  = 5'd11;
	localparam logic [4:0] S_NORM = 5'd12;
	localparam logic [4:0] S_DIV1 = 5'd13;
	localparam logic [4:0] S_DIV2 = 5'd14;
	localparam logic [4:0] S_MAG  = 5'd15;
	localparam logic [4:0] S_SIGN = 5'd16;
	localparam logic [4:0] S_HERR = 5'd17;
	localparam logic [4:0] S_HCHK = 5'd18;
	localparam logic [4:0] S_HMC  = 5'd19;
	localparam logic [4:0] S_HML  = 5'd20;
	localparam logic [4:0] S_OUT  = 5'd21;

	logic [4:0]         state_q;
	logic [CW-1:0]      cnt_q;
	logic [IW-1:0]      cur_q;
	logic [IW-1:0]      idx_q;
	logic               completed_q;
	logic               pass_q;
	logic               near_q;
	logic [15:0]        mtr_q;
	logic signed [31:0] rx_q;
	logic signed [31:0] ry_q;
	logic signed [15:0] yaw_q;
	logic signed [31:0] dx_q;
	logic signed [31:0] dy_q;
	logic [63:0]        dsq_q;
	logic signed [27:0] z_q;
	logic signed [35:0] x_q;
	logic signed [35:0] y_q;
	logic [4:0]         i_q;
	logic               ysign_q;
	logic signed [39:0] ly_q;
	logic [35:0]        num_q;
	logic [63:0]        den_q;
	logic [63:0]        curv_q;
	logic [24:0]        mag_q;
	logic [15:0]        lin_q;
	logic signed [26:0] ang_q;
	logic signed [17:0] err_q;
	logic [12:0]        corr_q;
	logic               rej_q;

	// Serial multiplier and divider registers
	logic [63:0] mul_a_q;
	logic [31:0] mul_b_q;
	logic [63:0] mul_acc_q;
	logic [64:0] rem_q;
	logic [63:0] dvd_q;
	logic [63:0] dsr_q;
	logic [6:0]  div_cnt_q;

	// Output register
	logic               out_valid_q;
	logic signed [15:0] lin_o_q;
	logic signed [15:0] ang_o_q;
	logic               done_o_q;
	logic [5:0]         idx_o_q;
	logic               rej_o_q;

	logic              accept;
	logic              ram_we;
	wppp_entry_t       wr_ent;
	logic [EW-1:0]     ram_rdata;
	wppp_entry_t       ent;

	logic signed [32:0] dx_full;
	logic signed [32:0] dy_full;
	logic signed [31:0] dx_sat;
	logic signed [31:0] dy_sat;
	logic [30:0]        dx_abs;
	logic [30:0]        dy_abs;
	logic [19:0]        tol20;
	logic [63:0]        mul_sum;
	logic [64:0]        div_sh;
	logic               div_ge;
	logic [64:0]        div_sub;
	logic signed [35:0] sh_x;
	logic signed [35:0] sh_y;
	logic signed [27:0] atan_i;
	logic [35:0]        y_abs;
	logic signed [63:0] gain_t;
	logic [39:0]        ly_abs;
	logic [63:0]        curv_min;
	logic [15:0]        sp_div;
	logic signed [17:0] err_raw;
	logic [15:0]        aerr;
	logic [CW-1:0]      idx_next;
	logic signed [15:0] ang_sat;
	logic signed [15:0] lin_sat;
	logic               out_free;

	assign accept    = in_valid && !in_stall;
	assign in_stall  = (state_q != S_IDLE);
	assign cfg_ready = 1'b1;
	assign out_free  = !out_valid_q || !out_stall;

	// Table write on an append that fits
	assign ram_we = accept && (op == OP_APPEND) && (cnt_q != CW'(WAYPOINTS));
	always_comb begin
		wr_ent.x    = pos_x;
		wr_ent.y    = pos_y;
		wr_ent.hdg  = heading;
		wr_ent.stop = stop_here;
		wr_ent.hv   = heading_valid;
		wr_ent.tol  = tolerance;
		wr_ent.spd  = travel_speed;
	end

	wppp_ram #(
		.WIDTH(EW),
		.DEPTH(WAYPOINTS)
	) u_table (
		.clk  (clk),
		.we   (ram_we),
		.waddr(cnt_q[IW-1:0]),
		.wdata(wr_ent),
		.raddr(idx_q),
		.rdata(ram_rdata)
	);

	assign ent = wppp_entry_t'(ram_rdata);

	// Datapath helpers
	always_comb begin
		// waypoint minus robot, saturated
		dx_full = $signed({ent.x[31], ent.x}) - $signed({rx_q[31], rx_q});
		dy_full = $signed({ent.y[31], ent.y}) - $signed({ry_q[31], ry_q});
		if (dx_full > COORD_MAX) begin
			dx_sat = COORD_MAX[31:0];
		end else if (dx_full < -COORD_MAX) begin
			dx_sat = 32'(-COORD_MAX);
		end else begin
			dx_sat = dx_full[31:0];
		end
		if (dy_full > COORD_MAX) begin
			dy_sat = COORD_MAX[31:0];
		end else if (dy_full < -COORD_MAX) begin
			dy_sat = 32'(-COORD_MAX);
		end else begin
			dy_sat = dy_full[31:0];
		end
		dx_abs = dx_q[31] ? 31'(-dx_q) : dx_q[30:0];
		dy_abs = dy_q[31] ? 31'(-dy_q) : dy_q[30:0];
		tol20  = {ent.tol, 4'b0};

		// one multiplier bit, one quotient bit
		mul_sum = mul_acc_q + mul_a_q;
		div_sh  = {rem_q[63:0], dvd_q[63]};
		div_ge  = (div_sh >= {1'b0, dsr_q});
		div_sub = div_sh - {1'b0, dsr_q};

		// CORDIC step operands
		sh_x   = x_q >>> i_q;
		sh_y   = y_q >>> i_q;
		atan_i = atan_z(i_q);

		// gain removal with round half up
		y_abs  = y_q[35] ? 36'(-y_q) : 36'(y_q);
		gain_t = ysign_q ? (64'sd8388608 - $signed(mul_acc_q))
		                 : ($signed(mul_acc_q) + 64'sd8388608);
		ly_abs = ly_q[39] ? 40'(-ly_q) : 40'(ly_q);

		curv_min = (curv_q > dvd_q) ? dvd_q : curv_q;
		sp_div   = (ent.spd < SPEED_FLOOR) ? SPEED_FLOOR : ent.spd;

		err_raw = 18'(ent.hdg) - 18'(yaw_q);
		aerr    = err_q[17] ? 16'(-err_q) : err_q[15:0];

		idx_next = CW'(idx_q) + CW'(1);

		// output saturation
		if (ang_q > 27'sd32767) begin
			ang_sat = 16'sh7fff;
		end else if (ang_q < -27'sd32768) begin
			ang_sat = -16'sh8000;
		end else begin
			ang_sat = ang_q[15:0];
		end
		lin_sat = lin_q[15] ? 16'sh7fff : $signed(lin_q);
	end

	// Sequencer, serial units and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			cur_q       <= '0;
			idx_q       <= '0;
			completed_q <= 1'b0;
			pass_q      <= 1'b0;
			near_q      <= 1'b0;
			mtr_q       <= MTR_RESET;
			rx_q        <= '0;
			ry_q        <= '0;
			yaw_q       <= '0;
			dx_q        <= '0;
			dy_q        <= '0;
			dsq_q       <= '0;
			z_q         <= '0;
			x_q         <= '0;
			y_q         <= '0;
			i_q         <= '0;
			ysign_q     <= 1'b0;
			ly_q        <= '0;
			num_q       <= '0;
			den_q       <= '0;
			curv_q      <= '0;
			mag_q       <= '0;
			lin_q       <= '0;
			ang_q       <= '0;
			err_q       <= '0;
			corr_q      <= '0;
			rej_q       <= 1'b0;
			mul_a_q     <= '0;
			mul_b_q     <= '0;
			mul_acc_q   <= '0;
			rem_q       <= '0;
			dvd_q       <= '0;
			dsr_q       <= '0;
			div_cnt_q   <= '0;
			out_valid_q <= 1'b0;
			lin_o_q     <= '0;
			ang_o_q     <= '0;
			done_o_q    <= 1'b0;
			idx_o_q     <= '0;
			rej_o_q     <= 1'b0;
		end else begin
			// configuration write
			if (cfg_valid) begin
				mtr_q <= cfg_data;
			end

			// drop a result once taken, unless a new one moves in
			if (out_valid_q && !out_stall && state_q != S_OUT) begin
				out_valid_q <= 1'b0;
			end

			// advance the multiplier while bits remain
			if (mul_b_q != '0) begin
				if (mul_b_q[0]) begin
					mul_acc_q <= mul_sum;
				end
				mul_a_q <= {mul_a_q[62:0], 1'b0};
				mul_b_q <= {1'b0, mul_b_q[31:1]};
			end

			// advance the divider while steps remain
			if (div_cnt_q != '0) begin
				rem_q     <= div_ge ? div_sub : div_sh;
				dvd_q     <= {dvd_q[62:0], div_ge};
				div_cnt_q <= div_cnt_q - 7'd1;
			end

			case (state_q)
				S_IDLE: begin
					if (accept) begin
						lin_q <= '0;
						ang_q <= '0;
						rej_q <= 1'b0;
						state_q <= S_OUT;
						case (op)
							OP_CLEAR: begin
								cnt_q       <= '0;
								cur_q       <= '0;
								completed_q <= 1'b0;
							end
							OP_APPEND: begin
								if (cnt_q == CW'(WAYPOINTS)) begin
									rej_q <= 1'b1;
								end else begin
									cnt_q <= cnt_q + CW'(1);
								end
							end
							OP_ODOM: begin
								if (cnt_q != '0 && !completed_q) begin
									rx_q    <= pos_x;
									ry_q    <= pos_y;
									yaw_q   <= heading;
									z_q     <= -(28'(heading) <<< 11);
									pass_q  <= 1'b0;
									idx_q   <= (CW'(cur_q) >= cnt_q) ? '0 : cur_q;
									state_q <= S_RD;
								end
							end
							default: begin
							end
						endcase
					end
				end

				// table read latency
				S_RD: begin
					state_q <= S_DIFF;
				end

				S_DIFF: begin
					dx_q    <= dx_sat;
					dy_q    <= dy_sat;
					state_q <= S_SQS;
				end

				S_SQS: begin
					mul_a_q   <= 64'(dx_abs);
					mul_b_q   <= 32'(dx_abs);
					mul_acc_q <= '0;
					state_q   <= S_SQX;
				end

				S_SQX: begin
					if (mul_b_q == '0) begin
						dsq_q     <= mul_acc_q;
						mul_a_q   <= 64'(dy_abs);
						mul_b_q   <= 32'(dy_abs);
						mul_acc_q <= '0;
						state_q   <= S_SQY;
					end
				end

				S_SQY: begin
					if (mul_b_q == '0) begin
						dsq_q <= dsq_q + mul_acc_q;
						if (pass_q) begin
							state_q <= S_ROTW;
						end else begin
							mul_a_q   <= 64'(tol20);
							mul_b_q   <= 32'(tol20);
							mul_acc_q <= '0;
							state_q   <= S_TOL;
						end
					end
				end

				// arrival and near tests
				S_TOL: begin
					if (mul_b_q == '0) begin
						near_q <= (dsq_q[63:32] == '0);
						if (dsq_q < mul_acc_q) begin
							if (ent.stop || idx_next >= cnt_q) begin
								completed_q <= 1'b1;
								state_q     <= S_OUT;
							end else begin
								idx_q   <= idx_next[IW-1:0];
								cur_q   <= idx_next[IW-1:0];
								pass_q  <= 1'b1;
								state_q <= S_RD;
							end
						end else begin
							state_q <= S_ROTW;
						end
					end
				end

				// wrap the angle into [-pi, pi]
				S_ROTW: begin
					x_q <= 36'(dx_q);
					y_q <= 36'(dy_q);
					if (z_q > PI_Z) begin
						z_q <= z_q - TWO_PI_Z;
					end else if (z_q < -PI_Z) begin
						z_q <= z_q + TWO_PI_Z;
					end
					state_q <= S_ROTF;
				end

				// fold into [-pi/2, pi/2]
				S_ROTF: begin
					if (z_q > HALF_PI_Z) begin
						x_q <= -x_q;
						y_q <= -y_q;
						z_q <= z_q - PI_Z;
					end else if (z_q < -HALF_PI_Z) begin
						x_q <= -x_q;
						y_q <= -y_q;
						z_q <= z_q + PI_Z;
					end
					i_q     <= '0;
					state_q <= S_CORD;
				end

				// one CORDIC micro-rotation per cycle
				S_CORD: begin
					if (i_q == 5'(CORDIC_STEPS)) begin
						ysign_q   <= y_q[35];
						mul_a_q   <= 64'(y_abs);
						mul_b_q   <= CORDIC_GAIN;
						mul_acc_q <= '0;
						state_q   <= S_GAIN;
					end else begin
						if (!z_q[27]) begin
							x_q <= x_q - sh_y;
							y_q <= y_q + sh_x;
							z_q <= z_q - atan_i;
						end else begin
							x_q <= x_q + sh_y;
							y_q <= y_q - sh_x;
							z_q <= z_q + atan_i;
						end
						i_q <= i_q + 5'd1;
					end
				end

				S_GAIN: begin
					if (mul_b_q == '0) begin
						ly_q    <= 40'(gain_t >>> 24);
						state_q <= S_NUM;
					end
				end

				S_NUM: begin
					num_q   <= {ly_abs[34:0], 1'b0};
					den_q   <= (dsq_q < DSQ_FLOOR) ? DSQ_FLOOR : dsq_q;
					state_q <= S_NORM;
				end

				// shift both until the numerator fits 31 bits
				S_NORM: begin
					if (num_q[35:31] != '0) begin
						num_q <= {1'b0, num_q[35:1]};
						den_q <= {1'b0, den_q[63:1]};
					end else begin
						rem_q     <= '0;
						dvd_q     <= {num_q[31:0], 32'b0};
						dsr_q     <= (den_q == '0) ? 64'd1 : den_q;
						div_cnt_q <= 7'd64;
						state_q   <= S_DIV1;
					end
				end

				// curvature quotient, then the turn limit
				S_DIV1: begin
					if (div_cnt_q == '0) begin
						curv_q    <= dvd_q;
						rem_q     <= '0;
						dvd_q     <= {mtr_q, 48'b0};
						dsr_q     <= 64'(sp_div);
						div_cnt_q <= 7'd32;
						state_q   <= S_DIV2;
					end
				end

				S_DIV2: begin
					if (div_cnt_q == '0) begin
						mul_a_q   <= curv_min;
						mul_b_q   <= 32'(ent.spd);
						mul_acc_q <= '0;
						state_q   <= S_MAG;
					end
				end

				S_MAG: begin
					if (mul_b_q == '0) begin
						mag_q   <= 25'((mul_acc_q + 64'd32768) >> 16);
						lin_q   <= ent.spd;
						state_q <= S_SIGN;
					end
				end

				S_SIGN: begin
					ang_q <= ly_q[39] ? -$signed({2'b0, mag_q}) : $signed({2'b0, mag_q});
					if (ent.hv && near_q) begin
						state_q <= S_HERR;
					end else begin
						state_q <= S_OUT;
					end
				end

				// heading error wrapped into [-pi, pi]
				S_HERR: begin
					if (err_raw > PI_Q13) begin
						err_q <= err_raw - TWO_PI_Q13;
					end else if (err_raw < -PI_Q13) begin
						err_q <= err_raw + TWO_PI_Q13;
					end else begin
						err_q <= err_raw;
					end
					state_q <= S_HCHK;
				end

				S_HCHK: begin
					if (aerr > ANGLE_THRESH) begin
						mul_a_q   <= 64'(aerr);
						mul_b_q   <= SLOW_Q16;
						mul_acc_q <= '0;
						state_q   <= S_HMC;
					end else begin
						state_q <= S_OUT;
					end
				end

				S_HMC: begin
					if (mul_b_q == '0) begin
						corr_q    <= 13'((mul_acc_q + 64'd65536) >> 17);
						mul_a_q   <= 64'(lin_q);
						mul_b_q   <= SLOW_Q16;
						mul_acc_q <= '0;
						state_q   <= S_HML;
					end
				end

				S_HML: begin
					if (mul_b_q == '0) begin
						lin_q <= 16'((mul_acc_q + 64'd32768) >> 16);
						if (err_q[17]) begin
							ang_q <= ang_q - $signed({14'b0, corr_q});
						end else begin
							ang_q <= ang_q + $signed({14'b0, corr_q});
						end
						state_q <= S_OUT;
					end
				end

				// hand the item to the output register
				S_OUT: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						lin_o_q     <= lin_sat;
						ang_o_q     <= ang_sat;
						done_o_q    <= completed_q;
						idx_o_q     <= 6'(cur_q);
						rej_o_q     <= rej_q;
						state_q     <= S_IDLE;
					end
				end

				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign out_valid      = out_valid_q;
	assign linear_speed   = lin_o_q;
	assign turn_rate      = ang_o_q;
	assign done_res       = done_o_q;
	assign waypoint_index = idx_o_q;
	assign rejected       = rej_o_q;

endmodule

// File: sv/wppp_ram.sv
// Generic single write port, single read port RAM with registered read data.
// No dependencies; used for the waypoint table.
module wppp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write on enable, read every cycle
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
